// ===== design/bitmap_frame_allocator_top_macros.svh =====
// Assertion macros of the bitmap frame allocator, used by bfa_ctrl.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define BFA_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap frame allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFA_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap frame allocator check failed");

`else

`define BFA_CHECK_NOW(label, ante, cons)
`define BFA_CHECK_NEXT(label, ante, cons)

`endif

`endif

// ===== design/bfa_pkg.sv =====
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

   localparam int FRAME_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;

   // Frames that a 12-bit frame number can name.
   localparam int FRAME_LIMIT = 4096;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam int DEF_NUM_FRAMES = 4096;
   localparam int DEF_WORD_BITS  = 32;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_ALREADY = 2'd1,
      ST_NOFREE  = 2'd2,
      ST_NOFRAME = 2'd3
   } status_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_out;
      logic               present;
      logic               writable;
      logic               user_mode;
      status_type         status;
   } rsp_type;

endpackage

// ===== design/bfa_chan_if.sv =====
// Request and response channel interfaces of the bitmap frame allocator.
interface bfa_req_if;
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [bfa_pkg::FRAME_W-1:0]     page_frame;
   logic                            sys_page;
   logic                            rw_page;

   modport source (output valid, opcode, page_frame, sys_page, rw_page,
                   input ready);
   modport sink (input valid, opcode, page_frame, sys_page, rw_page,
                 output ready);
endinterface

interface bfa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bfa_pkg::FRAME_W-1:0]     frame_out;
   logic                            present;
   logic                            writable;
   logic                            user_mode;
   logic [bfa_pkg::STATUS_W-1:0]    status;

   modport source (output valid, frame_out, present, writable, user_mode, status,
                   input ready);
   modport sink (input valid, frame_out, present, writable, user_mode, status,
                 output ready);
endinterface

// ===== design/bfa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bfa_ctrl.sv =====
// Sequencer of the allocator: bitmap clearing, word scan, free and result register.
`include "bitmap_frame_allocator_top_macros.svh"

module bfa_ctrl #(
   parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
   parameter int WORD_BITS  = bfa_pkg::DEF_WORD_BITS,
   localparam int NWORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS,
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bfa_pkg::COUNT_W-1:0]  limit,
   bfa_req_if.sink                      req_ch,
   bfa_rsp_if.source                    rsp_ch,
   output logic                         ram_wr_en,
   output logic [AW-1:0]                ram_wr_addr,
   output logic [WORD_BITS-1:0]         ram_wr_data,
   output logic                         ram_rd_en,
   output logic [AW-1:0]                ram_rd_addr,
   input  logic [WORD_BITS-1:0]         ram_rd_data
);

   localparam int SPAN  = NWORDS * WORD_BITS + WORD_BITS;
   localparam int CW    = ($clog2(SPAN + 1) > bfa_pkg::COUNT_W) ?
                          $clog2(SPAN + 1) : bfa_pkg::COUNT_W;
   localparam int BIW   = $clog2(WORD_BITS);
   localparam logic [AW-1:0]        LAST_WORD = AW'(NWORDS - 1);
   localparam logic [CW-1:0]        STEP      = CW'(WORD_BITS);
   localparam logic [CW-1:0]        TOP_FRAME = CW'(NUM_FRAMES);
   localparam logic [WORD_BITS-1:0] ONE_BIT   = WORD_BITS'(1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ASCAN = 6'b000100,
      S_FSEEK = 6'b001000,
      S_FMOD  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 word_ff, word_in;
   logic [CW-1:0]                 base_ff, base_in;
   logic [bfa_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic                          kern_ff, kern_in;
   logic                          wrt_ff, wrt_in;
   bfa_pkg::rsp_type              res_ff, res_in;
   bfa_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          req_ready;
   logic                          out_free;

   logic [CW-1:0]                 limit_ext;
   logic [CW-1:0]                 remain;
   logic [CW-1:0]                 next_base;
   logic [CW-1:0]                 frame_ext;
   logic [CW-1:0]                 alloc_frame;
   logic [WORD_BITS-1:0]          valid_mask;
   logic [WORD_BITS-1:0]          free_bits;
   logic [BIW-1:0]                first_idx;
   logic [BIW-1:0]                free_idx;
   logic                          found;

   assign limit_ext   = CW'(limit);
   assign remain      = limit_ext - base_ff;
   assign next_base   = base_ff + STEP;
   assign frame_ext   = CW'(frame_ff);
   assign alloc_frame = base_ff + CW'(first_idx);
   assign free_idx    = BIW'(frame_ext - base_ff);

   // The output register can take a new item when it is empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Lowest free bit of the word just read, among frames below the limit.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = (CW'(b) < remain);
      end
      free_bits = ~ram_rd_data & valid_mask;
      first_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            first_idx = BIW'(b);
         end
      end
      found = |free_bits;
   end

   // Next-state and memory access logic.
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      base_in      = base_ff;
      frame_in     = frame_ff;
      kern_in      = kern_ff;
      wrt_in       = wrt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = word_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = word_ff;

      // The output register empties when the sink takes the item.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               frame_in = req_ch.page_frame;
               kern_in  = req_ch.sys_page;
               wrt_in   = req_ch.rw_page;
               word_in  = '0;
               base_in  = '0;
               res_in   = '{frame_out: '0, present: 1'b0, writable: 1'b0,
                            user_mode: 1'b0, status: bfa_pkg::ST_OK};
               if (req_ch.opcode == bfa_pkg::OP_ALLOC) begin
                  if (req_ch.page_frame != '0) begin
                     res_in.frame_out = req_ch.page_frame;
                     res_in.status    = bfa_pkg::ST_ALREADY;
                     state_in         = S_DONE;
                  end else if (limit == '0) begin
                     res_in.status = bfa_pkg::ST_NOFREE;
                     state_in      = S_DONE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_ASCAN;
                  end
               end else begin
                  if (req_ch.page_frame == '0) begin
                     res_in.status = bfa_pkg::ST_NOFRAME;
                     state_in      = S_DONE;
                  end else if (CW'(req_ch.page_frame) >= TOP_FRAME) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FSEEK;
                  end
               end
            end
         end

         S_ASCAN: begin
            // Read the following word while this one is examined.
            ram_rd_en   = 1'b1;
            ram_rd_addr = word_ff + 1'b1;
            if (found) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | (ONE_BIT << first_idx);
               res_in      = '{frame_out: alloc_frame[bfa_pkg::FRAME_W-1:0],
                               present: 1'b1, writable: wrt_ff, user_mode: ~kern_ff,
                               status: bfa_pkg::ST_OK};
               state_in    = S_DONE;
            end else if (next_base >= limit_ext) begin
               res_in.status = bfa_pkg::ST_NOFREE;
               state_in      = S_DONE;
            end else begin
               word_in = word_ff + 1'b1;
               base_in = next_base;
            end
         end

         S_FSEEK: begin
            if (frame_ext < next_base) begin
               ram_rd_en = 1'b1;
               state_in  = S_FMOD;
            end else begin
               word_in = word_ff + 1'b1;
               base_in = next_base;
            end
         end

         S_FMOD: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data & ~(ONE_BIT << free_idx);
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      frame_ff <= frame_in;
      kern_ff  <= kern_in;
      wrt_ff   <= wrt_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.frame_out = rsp_ff.frame_out;
   assign rsp_ch.present   = rsp_ff.present;
   assign rsp_ch.writable  = rsp_ff.writable;
   assign rsp_ch.user_mode = rsp_ff.user_mode;
   assign rsp_ch.status    = rsp_ff.status;

   `BFA_CHECK_NOW(a_alloc_below_limit, state_ff == S_ASCAN && found, alloc_frame < limit_ext)
   `BFA_CHECK_NOW(a_alloc_sets_one_bit, state_ff == S_ASCAN && found, $onehot(ram_wr_data ^ ram_rd_data))
   `BFA_CHECK_NOW(a_free_clears_one_bit, state_ff == S_FMOD, $onehot0(ram_wr_data ^ ram_rd_data))
   `BFA_CHECK_NOW(a_no_rw_collision, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
   `BFA_CHECK_NEXT(a_result_loaded, state_ff == S_DONE && out_free, rsp_valid_ff && rsp_ff == $past(res_ff))

endmodule

// ===== design/bitmap_frame_allocator_top.sv =====
// Allocate: bitmap words are read in order from word 0 until a free frame below the count is found.
// Free: words are skipped up to the frame's word, which is read, its bit cleared and written back.
// Already allocated, zero count, nothing to free or a frame beyond the map: no bitmap access.
// One item at a time: the next item is taken the cycle after its result is loaded, and an item
// takes longer while an earlier result waits in the output register.
// After reset a clearing pass writes NWORDS words (128 by default); frame_count resets to 4096.
module bitmap_frame_allocator_top #(
   parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
   parameter int WORD_BITS  = bfa_pkg::DEF_WORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   bfa_req_if.sink                      req_ch,
   bfa_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [bfa_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int NWORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CAP    = (NUM_FRAMES < bfa_pkg::FRAME_LIMIT) ?
                           NUM_FRAMES : bfa_pkg::FRAME_LIMIT;
   localparam logic [bfa_pkg::COUNT_W-1:0] CAP_COUNT = bfa_pkg::COUNT_W'(CAP);

   logic [bfa_pkg::COUNT_W-1:0]  frame_count_ff, frame_count_in;
   logic [bfa_pkg::COUNT_W-1:0]  limit;
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [WORD_BITS-1:0]         ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [WORD_BITS-1:0]         ram_rd_data;

   // Frame count register.
   assign frame_count_in = csr_wr_en ? csr_wr_data : frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= bfa_pkg::COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   // Effective count, saturated to the frames that exist and can be named.
   assign limit = (frame_count_ff > CAP_COUNT) ? CAP_COUNT : frame_count_ff;

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bfa_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
